FILE: src/slcp_pkg.sv
// Package for the serial command line parser: parse phases, event codes,
// character constants, the result word type and character class helpers.
// Depends on nothing; used by slcp_core and serial_command_line_parser.
package slcp_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned ArgW  = 14;

  // Packed result width and the byte-padded stream width derived from it.
  localparam int unsigned ResW      = 1 + CharW + 1 + 2 + CharW + ArgW;
  localparam int unsigned ResBytesW = ((ResW + 7) / 8) * 8;

  localparam logic [CharW-1:0] ChZero   = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChNine   = 8'h39;  // '9'
  localparam logic [CharW-1:0] ChLowA   = 8'h61;  // 'a'
  localparam logic [CharW-1:0] ChLowZ   = 8'h7a;  // 'z'
  localparam logic [CharW-1:0] ChUpA    = 8'h41;  // 'A'
  localparam logic [CharW-1:0] ChUpZ    = 8'h5a;  // 'Z'
  localparam logic [CharW-1:0] ChCr     = 8'h0d;
  localparam logic [CharW-1:0] ChLf     = 8'h0a;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChCmdP   = 8'h70;  // 'p'
  localparam logic [CharW-1:0] ChCmdA   = 8'h61;  // 'a'
  localparam logic [CharW-1:0] ChCmdUpV = 8'h56;  // 'V'
  localparam logic [CharW-1:0] ChCmdS   = 8'h73;  // 's'
  localparam logic [CharW-1:0] ChCmdU   = 8'h75;  // 'u'
  localparam logic [CharW-1:0] ChCmdW   = 8'h77;  // 'w'
  localparam logic [CharW-1:0] ChCmdC   = 8'h63;  // 'c'
  localparam logic [CharW-1:0] ChCmdUpS = 8'h53;  // 'S'
  localparam logic [CharW-1:0] ChCmdUpC = 8'h43;  // 'C'
  localparam logic [CharW-1:0] ChCmdE   = 8'h65;  // 'e'
  localparam logic [CharW-1:0] ChCmdV   = 8'h76;  // 'v'

  typedef enum logic [2:0] {
    PH_DIG0   = 3'd0,
    PH_DIG1   = 3'd1,
    PH_DIG2   = 3'd2,
    PH_DIG3   = 3'd3,
    PH_LETTER = 3'd4,
    PH_SYNERR = 3'd5,
    PH_RETURN = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_SYNTAX  = 2'd1,
    EV_OK      = 2'd2,
    EV_UNKNOWN = 2'd3
  } event_e;

  // Field order from the highest bit down when packed.
  typedef struct packed {
    logic [ArgW-1:0]  argument;
    logic [CharW-1:0] command_letter;
    event_e           event_res;
    logic             echo_newline;
    logic [CharW-1:0] echo_char;
    logic             echo_valid;
  } result_t;

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_letter(input logic [CharW-1:0] c);
    return ((c >= ChLowA) && (c <= ChLowZ)) || ((c >= ChUpA) && (c <= ChUpZ));
  endfunction

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == ChLf) || (c == ChSpace);
  endfunction

  function automatic logic is_known(input logic [CharW-1:0] c,
                                    input logic [ArgW-1:0]  arg);
    logic known;
    known = 1'b0;
    case (c)
      ChCmdP, ChCmdA, ChCmdUpV, ChCmdS, ChCmdU,
      ChCmdW, ChCmdC, ChCmdUpS, ChCmdUpC, ChCmdE: known = 1'b1;
      ChCmdV:  known = (arg == '0);
      default: known = 1'b0;
    endcase
    return known;
  endfunction

endpackage

FILE: src/serial_command_line_parser.sv
// Serial command line parser, top level: stream handshake and result register
// around the parser core. Depends on slcp_pkg and slcp_core.
//
// Usage: each word on the slave stream is one received character. Lines are
// up to four decimal digits, one command letter and a carriage return; spaces
// and newlines are skipped where a digit or the return is awaited.
// Every accepted character yields exactly one word on the master stream: the
// character for echo with its echo flag, an extra-newline flag at a command's
// return, the event code (none, syntax error, accepted, unknown) and, for
// commands ended by their return, known or unknown, the letter and argument.
// The result word is registered and is offered in the cycle after acceptance.
// Throughput is one character per cycle while the receiver takes each word,
// set by the single result register, which is reloaded as its word is taken.
// Reset clears the parser to the start of a line with echo off and empties
// the result register. While the receiver stalls with a word pending, the
// slave side stops accepting characters until that word is taken.
module serial_command_line_parser import slcp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [CharW-1:0]     s_axis_tdata,   // [7:0] rx_char
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] echo_valid, [8:1] echo_char, [9] echo_newline, [11:10] event_res,
  // [19:12] command_letter, [33:20] argument, upper bits zero
  output logic [ResBytesW-1:0] m_axis_tdata
);

  logic    valid_q;
  result_t res_q;
  result_t core_res;
  logic    step;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  slcp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_char_i (s_axis_tdata),
    .result_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= core_res;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = ResBytesW'(res_q);

endmodule

FILE: src/slcp_core.sv
// Parser core: line phase, gathered argument, held letter and echo flag,
// with the result word for each character. Depends on slcp_pkg.
module slcp_core import slcp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] rx_char_i,
  output result_t          result_o
);

  phase_e           phase_q, phase_d;
  logic [ArgW-1:0]  arg_q, arg_d;
  logic [CharW-1:0] letter_q, letter_d;
  logic             echo_q, echo_d;
  logic [ArgW-1:0]  arg_next_digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DIG0;
      arg_q    <= '0;
      letter_q <= '0;
      echo_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      arg_q    <= arg_d;
      letter_q <= letter_d;
      echo_q   <= echo_d;
    end
  end

  // Times ten as two shifts; a decimal digit's value is its low nibble.
  assign arg_next_digit = (arg_q << 3) + (arg_q << 1) + ArgW'(rx_char_i[3:0]);

  always_comb begin
    phase_d  = phase_q;
    arg_d    = arg_q;
    letter_d = letter_q;
    echo_d   = echo_q;

    result_o.echo_valid     = echo_q;
    result_o.echo_char      = rx_char_i;
    result_o.echo_newline   = 1'b0;
    result_o.event_res      = EV_NONE;
    result_o.command_letter = '0;
    result_o.argument       = '0;

    unique case (phase_q)
      PH_DIG0, PH_DIG1, PH_DIG2, PH_DIG3: begin
        if (is_digit(rx_char_i)) begin
          arg_d   = arg_next_digit;
          phase_d = phase_e'(phase_q + 3'd1);
        end else if (is_letter(rx_char_i)) begin
          letter_d = rx_char_i;
          phase_d  = PH_RETURN;
        end else if (is_blank(rx_char_i)) begin
          phase_d = phase_q;
        end else if (rx_char_i == ChCr) begin
          // A return before any letter is a syntax error.
          result_o.event_res = EV_SYNTAX;
          phase_d            = PH_DIG0;
          arg_d              = '0;
        end else begin
          phase_d = PH_SYNERR;
        end
      end
      PH_LETTER: begin
        if (is_letter(rx_char_i)) begin
          letter_d = rx_char_i;
          phase_d  = PH_RETURN;
        end else begin
          phase_d = PH_SYNERR;
        end
      end
      PH_SYNERR: begin
        if (rx_char_i == ChCr) begin
          result_o.event_res = EV_SYNTAX;
          phase_d            = PH_DIG0;
          arg_d              = '0;
        end
      end
      PH_RETURN: begin
        if (is_blank(rx_char_i)) begin
          phase_d = phase_q;
        end else if (rx_char_i == ChCr) begin
          result_o.echo_newline   = echo_q;
          result_o.command_letter = letter_q;
          result_o.argument       = arg_q;
          if (is_known(letter_q, arg_q)) begin
            result_o.event_res = EV_OK;
            if (letter_q == ChCmdE) begin
              echo_d = (arg_q != '0);
            end
          end else begin
            result_o.event_res = EV_UNKNOWN;
          end
          phase_d = PH_DIG0;
          arg_d   = '0;
        end else begin
          phase_d = PH_SYNERR;
        end
      end
      default: begin
        // The unused phase holds everything as it is.
        phase_d = phase_q;
      end
    endcase
  end

endmodule
